@@ design/sdhl_pkg.sv @@
// Shared constants, codes and a helper function of the strip detector hit locator.
package sdhl_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 60;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL    = 3'd0,
    CFG_UP        = 3'd1,
    CFG_RIGHT     = 3'd2,
    CFG_OFFSET    = 3'd3,
    CFG_INTER_W   = 3'd4,
    CFG_GAP_ANGLE = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    HIT_PIXEL   = 2'd0,
    HIT_MISS    = 2'd1,
    HIT_OUTSIDE = 2'd2,
    HIT_GAP     = 2'd3
  } hit_status_e;

  localparam int unsigned RING_COUNT_DEF   = 24;
  localparam int unsigned SECTOR_COUNT_DEF = 32;

  localparam int unsigned INNER_RADIUS = 72090;
  localparam int unsigned STRIP_PITCH  = 6554;
  localparam int unsigned STRIP_SEMI   = 3277;

  localparam int unsigned CORDIC_STEPS = 28;
  localparam int unsigned SQRT_STEPS   = 21;
  localparam int unsigned QUOT_STEPS   = 42;
  localparam logic [33:0] CORDIC_GAIN  = 34'd652032874;

  localparam logic [59:0] NORMAL_RST = 60'd262144;
  localparam logic [59:0] UP_RST     = 60'd274877906944;
  localparam logic [59:0] RIGHT_RST  = 60'd864691128455135232;

  // Arc tangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] cordic_atan(input int unsigned i);
    logic [29:0] r;
    unique case (i)
      0:  r = 30'd536870912;
      1:  r = 30'd316933406;
      2:  r = 30'd167458907;
      3:  r = 30'd85004756;
      4:  r = 30'd42667331;
      5:  r = 30'd21354465;
      6:  r = 30'd10679838;
      7:  r = 30'd5340245;
      8:  r = 30'd2670163;
      9:  r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      24: r = 30'd41;
      25: r = 30'd20;
      26: r = 30'd10;
      27: r = 30'd5;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/sdhl_track_if.sv @@
// Track channel: direction angles and start point of one particle track.
interface sdhl_track_if;
  logic               valid;
  logic               ready;
  logic [15:0]        polar_angle;
  logic [15:0]        azimuth_angle;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;

  modport source(output valid, polar_angle, azimuth_angle, start_x, start_y, start_z,
                 input ready);
  modport sink(input valid, polar_angle, azimuth_angle, start_x, start_y, start_z,
               output ready);
endinterface

@@ design/sdhl_hit_if.sv @@
// Hit channel: status, pixel index and lab impact point of one track.
interface sdhl_hit_if;
  logic               valid;
  logic               ready;
  logic [1:0]         hit_status;
  logic [9:0]         pixel_number;
  logic signed [31:0] impact_x;
  logic signed [31:0] impact_y;
  logic signed [31:0] impact_z;

  modport source(output valid, hit_status, pixel_number, impact_x, impact_y, impact_z,
                 input ready);
  modport sink(input valid, hit_status, pixel_number, impact_x, impact_y, impact_z,
               output ready);
endinterface

@@ design/strip_detector_hit_locator.sv @@
// Strip detector hit locator: pipelined track to detector pixel mapping.
//
// Usage: tracks enter on trk_i (valid/ready), one item per accepted edge, and
// one result per track leaves on hit_o (valid/ready) in the same order.
// The plane and strip geometry is set through the write port cfg_we_i,
// cfg_idx_i and cfg_data_i; write it only while no track is in flight.
// Throughput: one track per clock cycle while the output register is empty or
// taken. The pipeline is a chain of 28 sine/cosine CORDIC steps, 42
// quotient bit steps, 28 vectoring CORDIC steps and the multiply and sum
// stages, one step per register stage.
// Reset clears the valid bits of every stage and restores the default
// geometry (normal along z, up along y, right along minus x, no offset,
// no gaps).
// When the receiver stalls, the whole pipeline holds and trk_i.ready drops
// only while the output register is full and not taken; nothing is lost
// or repeated.
module strip_detector_hit_locator #(
  parameter int unsigned RING_COUNT   = sdhl_pkg::RING_COUNT_DEF,
  parameter int unsigned SECTOR_COUNT = sdhl_pkg::SECTOR_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sdhl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdhl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sdhl_track_if.sink                      trk_i,
  sdhl_hit_if.source                      hit_o
);
  import sdhl_pkg::*;

  localparam int unsigned SECTOR_SPAN = 65536 / SECTOR_COUNT;
  localparam int unsigned RING_W      = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
  localparam int unsigned SEC_W       = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
  localparam int unsigned BAND_MAX    = INNER_RADIUS + RING_COUNT * STRIP_PITCH;
  localparam int unsigned NSTG        = 110;

  typedef logic [2:0][31:0] v32_t;
  typedef logic [2:0][33:0] v34_t;
  typedef logic [2:0][34:0] v35_t;

  typedef struct packed {
    logic signed [33:0] xt, yt, xp, yp;
    logic signed [32:0] zt, zp;
    logic               negt, negp;
    v32_t               s;
  } cs_t;

  typedef struct packed {
    v35_t d;
    v34_t rf;
    v32_t s;
  } b1_t;

  typedef struct packed {
    v35_t             d;
    v34_t             rf;
    v32_t             s;
    logic [2:0][54:0] pn;
    logic [2:0][54:0] pd;
  } b2_t;

  typedef struct packed {
    v35_t        d;
    v34_t        rf;
    v32_t        s;
    logic [56:0] num;
    logic [56:0] den;
  } b3_t;

  typedef struct packed {
    logic             miss;
    logic [56:0]      m;
    logic [2:0]       sg;
    logic [2:0][62:0] pl;
    logic [2:0][63:0] ph;
    v34_t             rf;
    v32_t             s;
  } c1_t;

  typedef struct packed {
    logic             miss;
    logic [56:0]      m;
    logic [2:0]       sg;
    logic [2:0][91:0] rem;
    logic [2:0][41:0] q;
    v34_t             rf;
    v32_t             s;
  } dv_t;

  typedef struct packed {
    logic             miss;
    logic [2:0][42:0] imp;
    logic [2:0][43:0] p;
  } e1_t;

  typedef struct packed {
    logic             miss;
    logic             far;
    v32_t             sat;
    logic [2:0][43:0] sqp;
    logic [2:0][41:0] pu;
    logic [2:0][41:0] pr;
  } e2_t;

  typedef struct packed {
    logic        miss;
    logic        far;
    v32_t        sat;
    logic [42:0] sq;
    logic [43:0] u;
    logic [43:0] v;
  } e3_t;

  typedef struct packed {
    logic               miss;
    logic               far;
    v32_t               sat;
    logic signed [46:0] x;
    logic signed [46:0] y;
    logic [31:0]        z;
    logic [42:0]        rem;
    logic [20:0]        res;
  } f_t;

  typedef struct packed {
    logic                    miss;
    logic                    far;
    logic                    band_out;
    v32_t                    sat;
    logic [RING_COUNT-1:0]   ring_hit;
    logic [SECTOR_COUNT-1:0] sec_hit;
  } g_t;

  // Configuration registers.
  logic [59:0] normal_q, up_q, right_q;
  logic [30:0] offset_q;
  logic [12:0] inter_w_q;
  logic [11:0] gap_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q  <= NORMAL_RST;
      up_q      <= UP_RST;
      right_q   <= RIGHT_RST;
      offset_q  <= '0;
      inter_w_q <= '0;
      gap_ang_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NORMAL:    normal_q  <= cfg_data_i;
        CFG_UP:        up_q      <= cfg_data_i;
        CFG_RIGHT:     right_q   <= cfg_data_i;
        CFG_OFFSET:    offset_q  <= cfg_data_i[30:0];
        CFG_INTER_W:   inter_w_q <= cfg_data_i[12:0];
        CFG_GAP_ANGLE: gap_ang_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [19:0] comp(input logic [59:0] pk, input int unsigned i);
    logic signed [19:0] r;
    unique case (i)
      0: r = $signed(pk[59:40]);
      1: r = $signed(pk[39:20]);
      default: r = $signed(pk[19:0]);
    endcase
    return r;
  endfunction

  // Handshake and valid bits.
  logic            adv;
  logic [NSTG-1:0] vld_q;

  assign adv         = !vld_q[NSTG-1] || hit_o.ready;
  assign trk_i.ready = adv;
  assign hit_o.valid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], trk_i.valid};
    end
  end

  // Sine and cosine of both track angles, one CORDIC step per stage.
  cs_t cs_q [CORDIC_STEPS+1];
  cs_t cs0_d;

  always_comb begin
    logic signed [32:0] zt, zp;
    zt = 33'($signed({trk_i.polar_angle, 16'h0000}));
    zp = 33'($signed({trk_i.azimuth_angle, 16'h0000}));
    cs0_d      = '0;
    cs0_d.xt   = $signed(CORDIC_GAIN);
    cs0_d.xp   = $signed(CORDIC_GAIN);
    cs0_d.s[0] = trk_i.start_x;
    cs0_d.s[1] = trk_i.start_y;
    cs0_d.s[2] = trk_i.start_z;
    // Fold the angle into the right half plane and flip the result back.
    if (zt > 33'sd1073741824) begin
      zt = zt - 33'sd2147483648;
      cs0_d.negt = 1'b1;
    end else if (zt < -33'sd1073741824) begin
      zt = zt + 33'sd2147483648;
      cs0_d.negt = 1'b1;
    end
    if (zp > 33'sd1073741824) begin
      zp = zp - 33'sd2147483648;
      cs0_d.negp = 1'b1;
    end else if (zp < -33'sd1073741824) begin
      zp = zp + 33'sd2147483648;
      cs0_d.negp = 1'b1;
    end
    cs0_d.zt = zt;
    cs0_d.zp = zp;
  end

  always_ff @(posedge clk_i) begin
    if (adv) cs_q[0] <= cs0_d;
  end

  function automatic cs_t cs_step(input cs_t a, input int unsigned i);
    cs_t b;
    logic signed [32:0] at;
    b  = a;
    at = $signed({3'b000, cordic_atan(i)});
    if (!a.zt[32]) begin
      b.xt = a.xt - (a.yt >>> i);
      b.yt = a.yt + (a.xt >>> i);
      b.zt = a.zt - at;
    end else begin
      b.xt = a.xt + (a.yt >>> i);
      b.yt = a.yt - (a.xt >>> i);
      b.zt = a.zt + at;
    end
    if (!a.zp[32]) begin
      b.xp = a.xp - (a.yp >>> i);
      b.yp = a.yp + (a.xp >>> i);
      b.zp = a.zp - at;
    end else begin
      b.xp = a.xp + (a.yp >>> i);
      b.yp = a.yp - (a.xp >>> i);
      b.zp = a.zp + at;
    end
    return b;
  endfunction

  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cs
    always_ff @(posedge clk_i) begin
      if (adv) cs_q[gi+1] <= cs_step(cs_q[gi], gi);
    end
  end

  // Direction vector and plane reference point.
  b1_t b1_d, b1_q;

  always_comb begin
    logic signed [33:0] ct, st, cp, sp;
    logic signed [67:0] m0, m1;
    logic signed [51:0] rp;
    cs_t a;
    a  = cs_q[CORDIC_STEPS];
    ct = a.negt ? -a.xt : a.xt;
    st = a.negt ? -a.yt : a.yt;
    cp = a.negp ? -a.xp : a.xp;
    sp = a.negp ? -a.yp : a.yp;
    m0 = 68'(st) * 68'(cp);
    m1 = 68'(st) * 68'(sp);
    b1_d.d[0] = 35'(m0 >>> 30);
    b1_d.d[1] = 35'(m1 >>> 30);
    b1_d.d[2] = 35'(ct);
    b1_d.s    = a.s;
    for (int i = 0; i < 3; i++) begin
      rp = 52'($signed({1'b0, offset_q})) * 52'(comp(normal_q, i));
      b1_d.rf[i] = 34'(rp >>> 18);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) b1_q <= b1_d;
  end

  // Products of the normal with (ref - start) and with the direction.
  b2_t b2_d, b2_q;

  always_comb begin
    logic signed [34:0] df;
    b2_d.d  = b1_q.d;
    b2_d.rf = b1_q.rf;
    b2_d.s  = b1_q.s;
    for (int i = 0; i < 3; i++) begin
      df = 35'($signed(b1_q.rf[i])) - 35'($signed(b1_q.s[i]));
      b2_d.pn[i] = 55'(df) * 55'(comp(normal_q, i));
      b2_d.pd[i] = 55'($signed(b1_q.d[i])) * 55'(comp(normal_q, i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) b2_q <= b2_d;
  end

  b3_t b3_d, b3_q;

  always_comb begin
    b3_d.d   = b2_q.d;
    b3_d.rf  = b2_q.rf;
    b3_d.s   = b2_q.s;
    b3_d.num = 57'($signed(b2_q.pn[0])) + 57'($signed(b2_q.pn[1]))
             + 57'($signed(b2_q.pn[2]));
    b3_d.den = 57'($signed(b2_q.pd[0])) + 57'($signed(b2_q.pd[1]))
             + 57'($signed(b2_q.pd[2]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) b3_q <= b3_d;
  end

  // Miss test and the magnitude product |num| * |d|, split in two halves.
  c1_t c1_d, c1_q;

  always_comb begin
    logic [56:0] a;
    logic [34:0] bm;
    a = b3_q.num[56] ? 57'(-$signed(b3_q.num)) : b3_q.num;
    c1_d.m    = b3_q.den[56] ? 57'(-$signed(b3_q.den)) : b3_q.den;
    c1_d.miss = (b3_q.den == '0)
             || ((b3_q.num != '0) && (b3_q.num[56] != b3_q.den[56]));
    c1_d.rf   = b3_q.rf;
    c1_d.s    = b3_q.s;
    for (int i = 0; i < 3; i++) begin
      bm = b3_q.d[i][34] ? 35'(-$signed(b3_q.d[i])) : b3_q.d[i];
      c1_d.pl[i] = 63'(a[27:0]) * 63'(bm);
      c1_d.ph[i] = 64'(a[56:28]) * 64'(bm);
      c1_d.sg[i] = b3_q.num[56] ^ b3_q.d[i][34] ^ b3_q.den[56];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) c1_q <= c1_d;
  end

  // Quotient by restoring division, one quotient bit per stage.
  dv_t dv_q [QUOT_STEPS+1];
  dv_t dv0_d;

  always_comb begin
    dv0_d.miss = c1_q.miss;
    dv0_d.m    = c1_q.m;
    dv0_d.sg   = c1_q.sg;
    dv0_d.rf   = c1_q.rf;
    dv0_d.s    = c1_q.s;
    dv0_d.q    = '0;
    for (int i = 0; i < 3; i++) begin
      dv0_d.rem[i] = (92'(c1_q.ph[i]) << 28) + 92'(c1_q.pl[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) dv_q[0] <= dv0_d;
  end

  function automatic dv_t dv_step(input dv_t a, input int unsigned k);
    dv_t b;
    logic [98:0] sh;
    b  = a;
    sh = 99'(a.m) << k;
    for (int i = 0; i < 3; i++) begin
      if ({7'b0, a.rem[i]} >= sh) begin
        b.rem[i]  = a.rem[i] - sh[91:0];
        b.q[i][k] = 1'b1;
      end
    end
    return b;
  endfunction

  for (genvar gk = 0; gk < QUOT_STEPS; gk++) begin : g_dv
    always_ff @(posedge clk_i) begin
      if (adv) dv_q[gk+1] <= dv_step(dv_q[gk], QUOT_STEPS - 1 - gk);
    end
  end

  // Impact point and its offset from the plane reference.
  e1_t e1_d, e1_q;

  always_comb begin
    logic [40:0]        qc;
    logic signed [42:0] sv;
    dv_t a;
    a = dv_q[QUOT_STEPS];
    e1_d.miss = a.miss;
    for (int i = 0; i < 3; i++) begin
      // A quotient beyond 2^40 saturates there.
      qc = (a.q[i] > 42'h100_0000_0000) ? 41'h100_0000_0000 : a.q[i][40:0];
      sv = a.sg[i] ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
      e1_d.imp[i] = 43'($signed(a.s[i])) + sv;
      e1_d.p[i]   = 44'($signed(e1_d.imp[i])) - 44'($signed(a.rf[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) e1_q <= e1_d;
  end

  // Range test, squares and projections on the in-plane axes.
  e2_t e2_d, e2_q;

  always_comb begin
    logic signed [43:0] p;
    logic signed [42:0] w;
    logic signed [21:0] pt;
    e2_d.miss = e1_q.miss;
    e2_d.far  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p  = $signed(e1_q.p[i]);
      w  = $signed(e1_q.imp[i]);
      pt = p[21:0];
      if (p > 44'sd1048576 || p < -44'sd1048576) e2_d.far = 1'b1;
      if (w > 43'sd2147483647) e2_d.sat[i] = 32'h7FFF_FFFF;
      else if (w < -43'sd2147483648) e2_d.sat[i] = 32'h8000_0000;
      else e2_d.sat[i] = w[31:0];
      e2_d.sqp[i] = 44'(pt) * 44'(pt);
      e2_d.pu[i]  = 42'(pt) * 42'(comp(up_q, i));
      e2_d.pr[i]  = 42'(pt) * 42'(comp(right_q, i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) e2_q <= e2_d;
  end

  e3_t e3_d, e3_q;

  always_comb begin
    e3_d.miss = e2_q.miss;
    e3_d.far  = e2_q.far;
    e3_d.sat  = e2_q.sat;
    e3_d.sq   = 43'(e2_q.sqp[0][40:0]) + 43'(e2_q.sqp[1][40:0])
              + 43'(e2_q.sqp[2][40:0]);
    e3_d.u    = 44'($signed(e2_q.pu[0])) + 44'($signed(e2_q.pu[1]))
              + 44'($signed(e2_q.pu[2]));
    e3_d.v    = 44'($signed(e2_q.pr[0])) + 44'($signed(e2_q.pr[1]))
              + 44'($signed(e2_q.pr[2]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) e3_q <= e3_d;
  end

  // Vectoring CORDIC for the sector angle, with the square root running
  // alongside, one result bit per stage in its first stages.
  f_t f_q [CORDIC_STEPS+1];
  f_t f0_d;

  always_comb begin
    logic signed [46:0] u, v;
    u = 47'($signed(e3_q.u));
    v = 47'($signed(e3_q.v));
    f0_d.miss = e3_q.miss;
    f0_d.far  = e3_q.far;
    f0_d.sat  = e3_q.sat;
    f0_d.rem  = e3_q.sq;
    f0_d.res  = '0;
    if (u < 0) begin
      f0_d.x = -u;
      f0_d.y = -v;
      f0_d.z = 32'h8000_0000;
    end else begin
      f0_d.x = u;
      f0_d.y = v;
      f0_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) f_q[0] <= f0_d;
  end

  function automatic f_t f_step(input f_t a, input int unsigned j);
    f_t b;
    logic [42:0] trial;
    int unsigned k;
    b = a;
    k = SQRT_STEPS - 1 - j;
    if (a.y > 0) begin
      b.x = a.x + (a.y >>> j);
      b.y = a.y - (a.x >>> j);
      b.z = a.z + 32'(cordic_atan(j));
    end else begin
      b.x = a.x - (a.y >>> j);
      b.y = a.y + (a.x >>> j);
      b.z = a.z - 32'(cordic_atan(j));
    end
    if (j < SQRT_STEPS) begin
      trial = (43'(a.res) << (k + 1)) + (43'(1) << (2 * k));
      if (a.rem >= trial) begin
        b.rem    = a.rem - trial;
        b.res[k] = 1'b1;
      end
    end
    return b;
  endfunction

  for (genvar gj = 0; gj < CORDIC_STEPS; gj++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (adv) f_q[gj+1] <= f_step(f_q[gj], gj);
    end
  end

  // Band, ring and sector windows, all compared side by side.
  g_t g_d, g_q;

  always_comb begin
    logic [23:0]        r;
    logic signed [24:0] r_dev;
    logic signed [25:0] eff;
    logic signed [35:0] lo, hi, ang;
    f_t a;
    a   = f_q[CORDIC_STEPS];
    r   = 24'(a.res);
    eff = 26'sd6554 - 26'($signed({1'b0, inter_w_q}));
    ang = $signed({4'b0000, a.z});
    g_d.miss     = a.miss;
    g_d.far      = a.far;
    g_d.sat      = a.sat;
    g_d.band_out = (r < 24'(INNER_RADIUS)) || (r > 24'(BAND_MAX));
    for (int i = 0; i < RING_COUNT; i++) begin
      r_dev = $signed({1'b0, r}) - 25'(INNER_RADIUS + (2 * i + 1) * STRIP_SEMI);
      if (r_dev < 0) r_dev = -r_dev;
      g_d.ring_hit[i] = (26'(r_dev) <<< 1) <= eff;
    end
    for (int i = 0; i < SECTOR_COUNT; i++) begin
      lo = 36'(i * SECTOR_SPAN) + $signed({24'h000000, gap_ang_q});
      hi = lo + 36'(SECTOR_SPAN) - $signed({23'h000000, gap_ang_q, 1'b0});
      g_d.sec_hit[i] = (ang >= (lo <<< 16)) && (ang <= (hi <<< 16));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) g_q <= g_d;
  end

  // Result register.
  hit_status_e status_q;
  logic [9:0]  pixel_q;
  v32_t        imp_q;

  hit_status_e status_d;
  logic [9:0]  pixel_d;
  v32_t        imp_d;

  always_comb begin
    logic [RING_W-1:0] ring;
    logic [SEC_W-1:0]  sec;
    logic              ring_ok, sec_ok;
    logic [15:0]       pix;
    ring    = '0;
    sec     = '0;
    ring_ok = 1'b0;
    sec_ok  = 1'b0;
    // The lowest matching ring and sector win.
    for (int i = RING_COUNT - 1; i >= 0; i--) begin
      if (g_q.ring_hit[i]) begin
        ring    = RING_W'(i);
        ring_ok = 1'b1;
      end
    end
    for (int i = SECTOR_COUNT - 1; i >= 0; i--) begin
      if (g_q.sec_hit[i]) begin
        sec    = SEC_W'(i);
        sec_ok = 1'b1;
      end
    end
    pix     = 16'(ring) * 16'(SECTOR_COUNT) + 16'(sec);
    pixel_d = '0;
    imp_d   = '0;
    priority if (g_q.miss) begin
      status_d = HIT_MISS;
    end else if (g_q.far || g_q.band_out) begin
      status_d = HIT_OUTSIDE;
    end else if (!ring_ok || !sec_ok) begin
      status_d = HIT_GAP;
      imp_d    = g_q.sat;
    end else begin
      status_d = HIT_PIXEL;
      imp_d    = g_q.sat;
      pixel_d  = pix[9:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= status_d;
      pixel_q  <= pixel_d;
      imp_q    <= imp_d;
    end
  end

  assign hit_o.hit_status   = status_q;
  assign hit_o.pixel_number = pixel_q;
  assign hit_o.impact_x     = imp_q[0];
  assign hit_o.impact_y     = imp_q[1];
  assign hit_o.impact_z     = imp_q[2];

  a_pixel_only_on_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid && (status_q != HIT_PIXEL) |-> (pixel_q == '0))
    else $error("pixel number set on a result that is not a pixel hit");

  a_no_impact_on_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid && (status_q == HIT_MISS || status_q == HIT_OUTSIDE)
    |-> (imp_q == '0))
    else $error("impact point set on a missed or out-of-band track");

  a_last_stage_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTG-2] && adv |=> vld_q[NSTG-1])
    else $error("item lost between the last stage and the result register");

  a_input_taken_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    trk_i.valid && adv |=> vld_q[0])
    else $error("accepted track did not enter the pipeline");

endmodule
